// File: rtl/gacc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gacc_pkg
// Shared types and codes for the gated audio capture controller.
// ----------------------------------------------------------------------------
package gacc_pkg;

  // word kinds on the input channel
  localparam logic [1:0] OP_SAMPLE  = 2'd0;
  localparam logic [1:0] OP_ECHO    = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;
  localparam logic [1:0] OP_COMMAND = 2'd3;

  // host command codes
  localparam logic [7:0] CMD_TIMED    = 8'd0;
  localparam logic [7:0] CMD_DISTANCE = 8'd1;
  localparam logic [7:0] CMD_STOP     = 8'd2;

  // configuration register indexes
  localparam logic [1:0] REG_OUTLIER  = 2'd0;
  localparam logic [1:0] REG_SILENCE  = 2'd1;
  localparam logic [1:0] REG_DEBOUNCE = 2'd2;

  // reset values of the configuration registers
  localparam logic [11:0] OUTLIER_RST  = 12'd4025;
  localparam logic [11:0] SILENCE_RST  = 12'd1985;
  localparam logic [2:0]  DEBOUNCE_RST = 3'd3;

  // mode codes as shown on the result channel
  localparam logic [2:0] MCODE_IDLE  = 3'd0;
  localparam logic [2:0] MCODE_TIMED = 3'd1;
  localparam logic [2:0] MCODE_NEAR  = 3'd2;
  localparam logic [2:0] MCODE_FAR   = 3'd3;
  localparam logic [2:0] MCODE_WAIT  = 3'd4;

  // block_done codes
  localparam logic [1:0] DONE_NONE  = 2'd0;
  localparam logic [1:0] DONE_FIRST = 2'd1;
  localparam logic [1:0] DONE_SECOND = 2'd2;

  // near test: cm * 20000 >= width * 343
  localparam int NEAR_SCALE = 20000;
  localparam int ECHO_SCALE = 343;
  localparam int LHS_W      = 23;  // 8b cm * 15b scale
  localparam int RHS_W      = 25;  // 16b width * 9b scale

  typedef enum logic [4:0] {
    RUN_IDLE  = 5'b00001,
    RUN_TIMED = 5'b00010,
    RUN_NEAR  = 5'b00100,
    RUN_FAR   = 5'b01000,
    RUN_WAIT  = 5'b10000
  } mode_t;

  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] c;
    case (m)
      RUN_IDLE:  c = MCODE_IDLE;
      RUN_TIMED: c = MCODE_TIMED;
      RUN_NEAR:  c = MCODE_NEAR;
      RUN_FAR:   c = MCODE_FAR;
      RUN_WAIT:  c = MCODE_WAIT;
      default:   c = MCODE_IDLE;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/gated_audio_capture_controller_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gated_audio_capture_controller_top
// Sample filter, ping-pong slot writer and echo-driven mode control.
// ----------------------------------------------------------------------------
// Takes one word per clock unless in_stall is high and returns exactly one
// result word per word taken (input register, then result register), for any
// mix of samples, echoes, timeouts and commands. The limit is the single
// state-update pass between those two registers: all running state (mode,
// slot, averager, debounce, block count) is read and rewritten in the same
// cycle the result is formed. in_stall rises only while a result sits in the
// output register and out_stall holds it. Configuration writes take effect
// on the next edge and belong in idle periods only.
module gated_audio_capture_controller_top #(
  parameter int HALF_DEPTH  = 1024,   // slots per ping-pong half, 16..1024
  parameter int SAMPLE_RATE = 44100   // samples per second, 8000..192000
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_operation,
  input  wire logic [15:0] in_sample_raw,
  input  wire logic [15:0] in_echo_width,
  input  wire logic [7:0]  in_command_code,
  input  wire logic [7:0]  in_command_argument,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_write_valid,
  output logic [10:0]      out_write_slot,
  output logic [11:0]      out_write_value,
  output logic [1:0]       out_block_done,
  output logic [2:0]       out_mode_now,
  output logic             out_indicator_led,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);
  import gacc_pkg::*;

  localparam int SLOT_W = $clog2(2 * HALF_DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_MID  = SLOT_W'(HALF_DEPTH - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(2 * HALF_DEPTH - 1);
  // have = blocks * HALF_DEPTH, want = seconds * SAMPLE_RATE
  localparam int HAVE_W = 16 + $clog2(HALF_DEPTH + 1);
  localparam int WANT_W = 8 + $clog2(SAMPLE_RATE + 1);
  localparam int CMP_W  = (HAVE_W > WANT_W) ? HAVE_W : WANT_W;

  // ---------------- configuration ----------------
  logic [11:0] outlier_r, silence_r;
  logic [2:0]  debounce_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outlier_r  <= OUTLIER_RST;
      silence_r  <= SILENCE_RST;
      debounce_r <= DEBOUNCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OUTLIER:  outlier_r  <= cfg_data;
        REG_SILENCE:  silence_r  <= cfg_data;
        REG_DEBOUNCE: debounce_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // ---------------- handshake ----------------
  // Input register frees up whenever the result register can take its word.
  logic s1_valid_r, out_valid_r;
  logic out_free, step_en, in_acc;

  assign out_free = !out_valid_r || !out_stall;
  assign step_en  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  logic [1:0]  s1_op_r;
  logic [15:0] s1_raw_r, s1_width_r;
  logic [7:0]  s1_code_r, s1_arg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (step_en) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r    <= in_operation;
      s1_raw_r   <= in_sample_raw;
      s1_width_r <= in_echo_width;
      s1_code_r  <= in_command_code;
      s1_arg_r   <= in_command_argument;
    end
  end

  // ---------------- running state ----------------
  mode_t             mode_r, mode_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [11:0]       tap0_r, tap0_nxt, tap1_r, tap1_nxt;
  logic [12:0]       sum_r, sum_nxt;
  logic              ptr_r, ptr_nxt;
  logic [11:0]       last_good_r, last_good_nxt;
  logic [2:0]        dcnt_r, dcnt_nxt;
  logic [15:0]       blocks_r, blocks_nxt;
  logic [HAVE_W-1:0] have_r, have_nxt;   // blocks_r * HALF_DEPTH, kept running
  logic [WANT_W-1:0] want_r, want_nxt;   // duration in samples
  logic [LHS_W-1:0]  lhs_r, lhs_nxt;     // distance limit * NEAR_SCALE
  logic              lamp_r, lamp_nxt;

  // step scratch
  logic              wr_en;
  logic [11:0]       wr_val;
  logic [1:0]        done;
  logic [11:0]       smp;
  logic [11:0]       old_tap;
  logic [RHS_W-1:0]  rhs;
  logic              echo_near;
  logic              choose_en;
  mode_t             target;
  logic [2:0]        dcnt_inc;
  logic              distance;

  assign rhs       = RHS_W'(s1_width_r) * RHS_W'(ECHO_SCALE);
  assign echo_near = RHS_W'(lhs_r) >= rhs;
  assign distance  = mode_r inside {RUN_NEAR, RUN_FAR, RUN_WAIT};
  assign smp       = s1_raw_r[11:0];
  assign old_tap   = ptr_r ? tap1_r : tap0_r;
  assign dcnt_inc  = dcnt_r + 3'd1;

  always_comb begin
    mode_nxt      = mode_r;
    slot_nxt      = slot_r;
    tap0_nxt      = tap0_r;
    tap1_nxt      = tap1_r;
    sum_nxt       = sum_r;
    ptr_nxt       = ptr_r;
    last_good_nxt = last_good_r;
    dcnt_nxt      = dcnt_r;
    blocks_nxt    = blocks_r;
    have_nxt      = have_r;
    want_nxt      = want_r;
    lhs_nxt       = lhs_r;
    lamp_nxt      = lamp_r;
    wr_en         = 1'b0;
    wr_val        = 12'd0;
    done          = DONE_NONE;
    choose_en     = 1'b0;
    target        = RUN_FAR;

    case (s1_op_r)
      OP_SAMPLE: begin
        if (mode_r inside {RUN_IDLE, RUN_TIMED, RUN_NEAR}) begin
          wr_en = 1'b1;
          if (s1_raw_r > {4'd0, outlier_r}) begin
            // spike: repeat last good value
            wr_val = last_good_r;
          end else begin
            sum_nxt = sum_r - {1'b0, old_tap} + {1'b0, smp};
            if (ptr_r) tap1_nxt = smp;
            else       tap0_nxt = smp;
            ptr_nxt       = ~ptr_r;
            wr_val        = sum_nxt[12:1];
            last_good_nxt = sum_nxt[12:1];
          end
        end else if (mode_r == RUN_FAR) begin
          wr_en  = 1'b1;
          wr_val = silence_r;
        end
        if (wr_en) begin
          if (slot_r == SLOT_MID)       done = DONE_FIRST;
          else if (slot_r == SLOT_LAST) done = DONE_SECOND;
          slot_nxt = (slot_r == SLOT_LAST) ? '0 : slot_r + SLOT_W'(1);
          if (done != DONE_NONE && mode_r != RUN_IDLE && blocks_r != 16'hFFFF) begin
            blocks_nxt = blocks_r + 16'd1;
            have_nxt   = have_r + HAVE_W'(HALF_DEPTH);
          end
        end
      end
      OP_ECHO: begin
        choose_en = distance;
        target    = echo_near ? RUN_NEAR : RUN_FAR;
      end
      OP_TIMEOUT: begin
        choose_en = distance;
        target    = RUN_FAR;
      end
      OP_COMMAND: begin
        // every command restarts the buffer and presets the averager
        blocks_nxt = 16'd0;
        have_nxt   = '0;
        slot_nxt   = '0;
        tap0_nxt   = silence_r;
        tap1_nxt   = silence_r;
        sum_nxt    = {silence_r, 1'b0};
        ptr_nxt    = 1'b0;
        case (s1_code_r)
          CMD_TIMED: begin
            want_nxt = WANT_W'(s1_arg_r) * WANT_W'(SAMPLE_RATE);
            mode_nxt = RUN_TIMED;
            lamp_nxt = 1'b1;
          end
          CMD_DISTANCE: begin
            lhs_nxt  = LHS_W'(s1_arg_r) * LHS_W'(NEAR_SCALE);
            mode_nxt = RUN_WAIT;
          end
          CMD_STOP: begin
            mode_nxt = RUN_IDLE;
            lamp_nxt = 1'b0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    // debounced mode change; first reading after a trigger switches at once
    if (choose_en) begin
      if (target == mode_r) begin
        dcnt_nxt = 3'd0;
      end else if (dcnt_inc >= debounce_r || mode_r == RUN_WAIT) begin
        mode_nxt = target;
        lamp_nxt = (target == RUN_NEAR);
        dcnt_nxt = 3'd0;
      end else begin
        dcnt_nxt = dcnt_inc;
      end
    end

    // timed recording ends once enough samples are banked
    if (mode_nxt == RUN_TIMED && CMP_W'(have_nxt) >= CMP_W'(want_nxt)) begin
      mode_nxt = RUN_IDLE;
      lamp_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= RUN_IDLE;
      slot_r      <= '0;
      tap0_r      <= SILENCE_RST;
      tap1_r      <= SILENCE_RST;
      sum_r       <= {SILENCE_RST, 1'b0};
      ptr_r       <= 1'b0;
      last_good_r <= SILENCE_RST;
      dcnt_r      <= 3'd0;
      blocks_r    <= 16'd0;
      have_r      <= '0;
      want_r      <= '0;
      lhs_r       <= '0;
      lamp_r      <= 1'b0;
    end else if (step_en) begin
      mode_r      <= mode_nxt;
      slot_r      <= slot_nxt;
      tap0_r      <= tap0_nxt;
      tap1_r      <= tap1_nxt;
      sum_r       <= sum_nxt;
      ptr_r       <= ptr_nxt;
      last_good_r <= last_good_nxt;
      dcnt_r      <= dcnt_nxt;
      blocks_r    <= blocks_nxt;
      have_r      <= have_nxt;
      want_r      <= want_nxt;
      lhs_r       <= lhs_nxt;
      lamp_r      <= lamp_nxt;
    end
  end

  // ---------------- result register ----------------
  logic        res_wv_r;
  logic [10:0] res_slot_r;
  logic [11:0] res_val_r;
  logic [1:0]  res_done_r;
  logic [2:0]  res_mode_r;
  logic        res_led_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_wv_r   <= wr_en;
      res_slot_r <= wr_en ? 11'(slot_r) : 11'd0;
      res_val_r  <= wr_val;
      res_done_r <= done;
      res_mode_r <= mode_code(mode_nxt);
      res_led_r  <= lamp_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_valid   = res_wv_r;
  assign out_write_slot    = res_slot_r;
  assign out_write_value   = res_val_r;
  assign out_block_done    = res_done_r;
  assign out_mode_now      = res_mode_r;
  assign out_indicator_led = res_led_r;

endmodule
`default_nettype wire

// File: rtl/gacc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gacc_checker
// Port-level checks for the gated audio capture controller.
// ----------------------------------------------------------------------------
module gacc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_write_valid,
  input wire logic [10:0] out_write_slot,
  input wire logic [11:0] out_write_value,
  input wire logic [1:0]  out_block_done,
  input wire logic [2:0]  out_mode_now,
  input wire logic        out_indicator_led
);
  import gacc_pkg::*;

  // no write: payload fields are zero
  a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_write_valid) |->
      (out_write_slot == 11'd0 && out_write_value == 12'd0 &&
       out_block_done == DONE_NONE))
    else $error("nonzero payload on a word without a write");

  // a filled half is only ever reported with a write
  a_done_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_block_done != DONE_NONE) |-> out_write_valid)
    else $error("block_done without a write");

  // lamp tracks the recording modes
  a_lamp_on: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_mode_now == MCODE_TIMED || out_mode_now == MCODE_NEAR))
      |-> out_indicator_led)
    else $error("lamp off while recording");

  a_lamp_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_mode_now == MCODE_IDLE || out_mode_now == MCODE_FAR))
      |-> !out_indicator_led)
    else $error("lamp on while not recording");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_write_slot) && $stable(out_write_value) &&
       $stable(out_mode_now)))
    else $error("result changed while stalled");

endmodule

bind gated_audio_capture_controller_top gacc_checker u_gacc_checker (.*);
`default_nettype wire

// File: sim/gated_audio_capture_controller_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_audio_capture_controller_top_test
// Self-checking bench: every word sent is run through a local model of the
// capture controller (filter, slot writer, debounced distance modes, timed
// run-out) and each result word is compared field by field, in order.
// ----------------------------------------------------------------------------
module gated_audio_capture_controller_top_test;
  import gacc_pkg::*;

  localparam int HALF_SLOTS  = 1024;
  localparam int RATE_HZ     = 44100;
  localparam int CLK_HALF_NS = 6;         // 12 ns period
  localparam int RESET_CYCLES = 6;
  localparam int DRAIN_CYCLES = 4;        // result passes the input and result registers
  localparam int CYCLE_LIMIT  = 600000;   // slowest legal run is well under this
  localparam int WORDS_PER_PHASE = 40;
  localparam int MAX_REPORTS  = 10;

  // one result word, field order as on the result channel
  typedef struct packed {
    logic        wv;
    logic [10:0] slot;
    logic [11:0] value;
    logic [1:0]  done;
    logic [2:0]  mode;
    logic        led;
  } capture_result_t;

  // --------------------------------------------------------------------------
  // DUT ports; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = OP_SAMPLE;
  logic [15:0] in_sample_raw = '0;
  logic [15:0] in_echo_width = '0;
  logic [7:0]  in_command_code = '0;
  logic [7:0]  in_command_argument = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_write_valid;
  logic [10:0] out_write_slot;
  logic [11:0] out_write_value;
  logic [1:0]  out_block_done;
  logic [2:0]  out_mode_now;
  logic        out_indicator_led;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_OUTLIER;
  logic [11:0] cfg_data = '0;

  gated_audio_capture_controller_top #(
    .HALF_DEPTH (HALF_SLOTS),
    .SAMPLE_RATE(RATE_HZ)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_sample_raw      (in_sample_raw),
    .in_echo_width      (in_echo_width),
    .in_command_code    (in_command_code),
    .in_command_argument(in_command_argument),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_write_valid    (out_write_valid),
    .out_write_slot     (out_write_slot),
    .out_write_value    (out_write_value),
    .out_block_done     (out_block_done),
    .out_mode_now       (out_mode_now),
    .out_indicator_led  (out_indicator_led),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Model state: a shadow of the controller, advanced once per accepted word.
  // Config shadows follow the register writes the bench makes.
  // --------------------------------------------------------------------------
  logic [11:0] lim_outlier;
  logic [11:0] lvl_silence;
  logic [2:0]  need_debounce;

  logic [2:0]  pm_mode;
  int          pm_slot;
  logic [11:0] pm_taps [2];
  logic [12:0] pm_sum;
  logic        pm_ptr;
  logic [11:0] pm_last_good;
  logic [2:0]  pm_debounce;
  int          pm_blocks;       // saturates at 16 bits
  logic [7:0]  pm_seconds;
  logic [7:0]  pm_cm;
  logic        pm_lamp;

  capture_result_t pending_results[$];

  // run bookkeeping
  int gap_pct = 0;              // chance per cycle that the sender holds off
  int stall_pct = 0;            // chance per cycle that the receiver stalls
  int cycle_count = 0;
  int words_sent = 0;
  int results_checked = 0;
  int writes_seen = 0;
  int halves_seen = 0;
  int mode_switches = 0;
  int timed_runouts = 0;
  int mismatches = 0;

  // --------------------------------------------------------------------------
  // Clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               pending_results.size());
      $display("[gated_audio_capture_controller_top] ERROR");
      $finish;
    end
  end

  // Receiver: random stall per cycle at the current phase's rate.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------
  // Averager preset; done by reset and by every host command.
  function automatic void preset_filter();
    pm_taps[0] = lvl_silence;
    pm_taps[1] = lvl_silence;
    pm_sum     = {lvl_silence, 1'b0};
    pm_ptr     = 1'b0;
  endfunction

  function automatic void reset_capture_model();
    lim_outlier   = OUTLIER_RST;
    lvl_silence   = SILENCE_RST;
    need_debounce = DEBOUNCE_RST;
    pm_mode       = MCODE_IDLE;
    pm_slot       = 0;
    preset_filter();
    pm_last_good  = lvl_silence;
    pm_debounce   = '0;
    pm_blocks     = 0;
    pm_seconds    = '0;
    pm_cm         = '0;
    pm_lamp       = 1'b0;
  endfunction

  // A reading that agrees with the mode clears the count; enough disagreeing
  // readings in a row switch it. The very first reading after a distance
  // command always switches. The 3-bit count wraps.
  function automatic void debounce_distance_mode(input logic [2:0] target);
    if (target == pm_mode) begin
      pm_debounce = '0;
      return;
    end
    pm_debounce = pm_debounce + 3'd1;
    if (pm_debounce >= need_debounce || pm_mode == MCODE_WAIT) begin
      pm_mode     = target;
      pm_lamp     = (target == MCODE_NEAR);
      pm_debounce = '0;
      mode_switches++;
    end
  endfunction

  function automatic capture_result_t predict_capture(input logic [1:0]  op,
                                                      input logic [15:0] raw,
                                                      input logic [15:0] width,
                                                      input logic [7:0]  code,
                                                      input logic [7:0]  arg);
    capture_result_t r;
    logic in_distance;
    logic wr;
    int   s;
    int   lhs;
    int   rhs;
    r  = '0;
    wr = 1'b0;
    in_distance = (pm_mode == MCODE_NEAR) || (pm_mode == MCODE_FAR) ||
                  (pm_mode == MCODE_WAIT);
    case (op)
      OP_SAMPLE: begin
        if (pm_mode == MCODE_IDLE || pm_mode == MCODE_TIMED || pm_mode == MCODE_NEAR) begin
          if (raw > {4'b0, lim_outlier}) begin
            // spike: repeat the last good value, filter untouched
            r.value = pm_last_good;
          end else begin
            pm_sum          = pm_sum - pm_taps[pm_ptr] + raw[11:0];
            pm_taps[pm_ptr] = raw[11:0];
            pm_ptr          = ~pm_ptr;
            r.value         = pm_sum[12:1];
            pm_last_good    = r.value;
          end
          wr = 1'b1;
        end else if (pm_mode == MCODE_FAR) begin
          r.value = lvl_silence;
          wr      = 1'b1;
        end
        // waiting for the first echo: nothing written
        if (wr) begin
          s      = pm_slot % (2 * HALF_SLOTS);
          r.wv   = 1'b1;
          r.slot = 11'(s);
          if (s == HALF_SLOTS - 1) r.done = DONE_FIRST;
          else if (s == 2 * HALF_SLOTS - 1) r.done = DONE_SECOND;
          s++;
          if (s >= 2 * HALF_SLOTS) s = 0;
          pm_slot = s;
          // half-buffers only count outside idle
          if (r.done != DONE_NONE && pm_mode != MCODE_IDLE && pm_blocks < 65535)
            pm_blocks++;
        end
      end
      OP_ECHO: begin
        if (in_distance) begin
          lhs = int'(pm_cm) * NEAR_SCALE;
          rhs = int'(width) * ECHO_SCALE;
          debounce_distance_mode((lhs >= rhs) ? MCODE_NEAR : MCODE_FAR);
        end
      end
      OP_TIMEOUT: begin
        if (in_distance) debounce_distance_mode(MCODE_FAR);
      end
      default: begin
        // any command restarts the buffer; unknown codes stop there
        pm_blocks = 0;
        pm_slot   = 0;
        preset_filter();
        if (code == CMD_TIMED) begin
          pm_seconds = arg;
          pm_mode    = MCODE_TIMED;
          pm_lamp    = 1'b1;
        end else if (code == CMD_DISTANCE) begin
          pm_cm   = arg;
          pm_mode = MCODE_WAIT;
        end else if (code == CMD_STOP) begin
          pm_mode = MCODE_IDLE;
          pm_lamp = 1'b0;
        end
      end
    endcase
    // timed capture ends once enough samples are stored; zero seconds ends at once
    if (pm_mode == MCODE_TIMED &&
        longint'(pm_blocks) * HALF_SLOTS >= longint'(pm_seconds) * RATE_HZ) begin
      pm_mode = MCODE_IDLE;
      pm_lamp = 1'b0;
      timed_runouts++;
    end
    r.mode = pm_mode;
    r.led  = pm_lamp;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: each accepted result word against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    capture_result_t got;
    capture_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_write_valid, out_write_slot, out_write_value, out_block_done,
             out_mode_now, out_indicator_led};
      results_checked++;
      if (got.wv === 1'b1) writes_seen++;
      if (got.done !== DONE_NONE) halves_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("cycle %0d: result word with nothing expected: %h", cycle_count, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"cycle %0d result %0d (exp/got): wv %0d/%0d slot %0d/%0d ",
                      "value %0d/%0d done %0d/%0d mode %0d/%0d led %0d/%0d"},
                     cycle_count, results_checked, want.wv, got.wv, want.slot, got.slot,
                     want.value, got.value, want.done, got.done, want.mode, got.mode,
                     want.led, got.led);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks. All are entered just after a rising edge. The sender does
  // not drop valid after a word is taken; the next call either keeps it high
  // or opens a gap, so valid never gets two updates in one step.
  // --------------------------------------------------------------------------
  task automatic send_word(input logic [1:0]  op,
                           input logic [15:0] raw,
                           input logic [15:0] width,
                           input logic [7:0]  code,
                           input logic [7:0]  arg);
    while ($urandom_range(99) < gap_pct) begin
      in_valid            <= 1'b0;
      in_operation        <= 2'($urandom);   // junk while idle
      in_sample_raw       <= 16'($urandom);
      in_echo_width       <= 16'($urandom);
      in_command_code     <= 8'($urandom);
      in_command_argument <= 8'($urandom);
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_operation        <= op;
    in_sample_raw       <= raw;
    in_echo_width       <= width;
    in_command_code     <= code;
    in_command_argument <= arg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_capture(op, raw, width, code, arg));
    words_sent++;
  endtask

  // Stop sending and let every outstanding result come back.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers back to back; only while drained.
  task automatic write_settings(input logic [11:0] outlier,
                                input logic [11:0] silence,
                                input logic [2:0]  debounce);
    logic [11:0] vals [3];
    vals[REG_OUTLIER]  = outlier;
    vals[REG_SILENCE]  = silence;
    vals[REG_DEBOUNCE] = {9'b0, debounce};
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we        <= 1'b0;
    lim_outlier   = outlier;
    lvl_silence   = silence;
    need_debounce = debounce;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Hand-picked words on reset settings: spike edges, ignored echoes, the
  // command set, first-reading switch, debounce restart, far-mode silence.
  task automatic test_directed_corners();
    send_word(OP_SAMPLE, 16'd0, '0, '0, '0);
    send_word(OP_SAMPLE, 16'd4025, '0, '0, '0);        // at the limit: filtered
    send_word(OP_SAMPLE, 16'd4026, '0, '0, '0);        // just above: spike
    send_word(OP_SAMPLE, 16'hFFFF, '0, '0, '0);
    send_word(OP_ECHO, '0, 16'd0, '0, '0);             // ignored while idle
    send_word(OP_TIMEOUT, '0, '0, '0, '0);
    send_word(OP_COMMAND, '0, '0, 8'hFF, 8'hFF);       // unknown code: restart only
    send_word(OP_COMMAND, '0, '0, CMD_TIMED, 8'd0);    // zero seconds: done at once
    send_word(OP_COMMAND, '0, '0, CMD_DISTANCE, 8'd0);
    send_word(OP_SAMPLE, 16'd1234, '0, '0, '0);        // waiting: no write
    send_word(OP_TIMEOUT, '0, '0, '0, '0);             // first reading switches to far
    send_word(OP_SAMPLE, 16'd77, '0, '0, '0);          // far: silence written
    send_word(OP_ECHO, '0, 16'd0, '0, '0);             // 0 >= 0: near reading
    send_word(OP_ECHO, '0, 16'd0, '0, '0);
    send_word(OP_ECHO, '0, 16'hFFFF, '0, '0);          // agrees with far: count restarts
    repeat (3) send_word(OP_ECHO, '0, 16'd0, '0, '0);  // third one switches to near
    send_word(OP_SAMPLE, 16'd4095, '0, '0, '0);
    send_word(OP_SAMPLE, 16'd100, '0, '0, '0);
    send_word(OP_COMMAND, '0, '0, CMD_DISTANCE, 8'hFF);
    send_word(OP_ECHO, '0, 16'hFFFF, '0, '0);
    send_word(OP_COMMAND, '0, '0, CMD_TIMED, 8'd1);
    send_word(OP_ECHO, '0, 16'd0, '0, '0);             // ignored in timed mode
    send_word(OP_COMMAND, '0, '0, CMD_STOP, 8'd0);
  endtask

  // A one-second timed capture writes past the end of the first half-buffer;
  // the half counts toward the run but falls far short of it, so the mode
  // stays timed until the closing stop.
  task automatic test_timed_half_fill();
    wait_until_drained();
    write_settings(12'd2500, 12'd2048, 3'd2);
    gap_pct   = 9;
    stall_pct = 9;
    send_word(OP_COMMAND, '0, '0, CMD_TIMED, 8'd1);
    while (pm_slot < HALF_SLOTS + 4) begin
      if ($urandom_range(63) == 0)
        send_word(OP_ECHO, '0, 16'($urandom), '0, '0);
      else
        send_word(OP_SAMPLE, 16'($urandom_range(2600)), '0, '0, '0);
    end
    send_word(OP_COMMAND, '0, '0, CMD_STOP, 8'd0);
  endtask

  // Four phases, each with its own settings, gap and stall rates. Mostly
  // distance sessions (commands, echoes near the threshold, timeouts,
  // samples) with timed runs, stops and arbitrary commands mixed in.
  task automatic test_random_phases();
    int          sent;
    int          pick;
    int          thr;
    logic [1:0]  op;
    logic [15:0] raw;
    logic [15:0] width;
    logic [7:0]  code;
    logic [7:0]  arg;
    for (int phase = 0; phase < 4; phase++) begin
      wait_until_drained();
      case (phase)
        0: begin
          write_settings(12'd4095, 12'd0, 3'd7);
          gap_pct = 0;  stall_pct = 0;
        end
        1: begin
          write_settings(12'd0, 12'd4095, 3'd0);
          gap_pct = 47; stall_pct = 0;
        end
        2: begin
          write_settings(12'($urandom), 12'($urandom), 3'd1);
          gap_pct = 0;  stall_pct = 47;
        end
        default: begin
          write_settings(12'($urandom_range(1000, 4095)), 12'($urandom), 3'($urandom));
          gap_pct = 9;  stall_pct = 9;
        end
      endcase
      sent = 0;
      while (sent < WORDS_PER_PHASE) begin
        pick  = $urandom_range(99);
        op    = OP_SAMPLE;
        raw   = 16'($urandom);
        width = 16'($urandom);
        code  = 8'($urandom);
        arg   = 8'($urandom);
        if (pick < 7) begin
          op   = OP_COMMAND;
          code = CMD_DISTANCE;
        end else if (pick < 10) begin
          op   = OP_COMMAND;
          code = CMD_TIMED;
          if ($urandom_range(1) == 1) arg = 8'($urandom_range(1));
        end else if (pick < 12) begin
          op   = OP_COMMAND;
          code = CMD_STOP;
        end else if (pick < 14) begin
          op = OP_COMMAND;                     // any code at all
        end else if (pick < 44) begin
          op = OP_ECHO;
          // mostly right around the near/far boundary for the current range
          if ($urandom_range(3) != 0) begin
            thr = (int'(pm_cm) * NEAR_SCALE) / ECHO_SCALE + int'($urandom_range(4)) - 2;
            if (thr < 0) thr = 0;
            width = 16'(thr);
          end
        end else if (pick < 54) begin
          op = OP_TIMEOUT;
        end else if ($urandom_range(3) != 0) begin
          raw = 16'($urandom_range(4095));
        end
        sent++;
        send_word(op, raw, width, code, arg);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    reset_capture_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_corners();
    test_timed_half_fill();
    test_random_phases();
    wait_until_drained();

    $display("Ran %0d words: directed corners, a timed capture past the first half-buffer,",
             words_sent);
    $display({"and four random phases with idling; %0d results checked, %0d writes, ",
              "%0d half-buffers, %0d mode switches, %0d timed run-outs."},
             results_checked, writes_seen, halves_seen, mode_switches, timed_runouts);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[gated_audio_capture_controller_top] OK");
    end else begin
      $display("%0d mismatching results", mismatches);
      $display("[gated_audio_capture_controller_top] ERROR");
    end
    $finish;
  end

endmodule
